FILE: design/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the two-level page walker
// Transaction formats, result kinds, state encodings and width helpers used
// by the front end, the command queue, the walk engine and the TLB store.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

   // Default number of direct-mapped TLB entries.
   localparam int TLB_ENTRIES_DEFAULT = 64;

   // Virtual page number width of a 32-bit linear address with 4 KiB pages.
   localparam int VPN_W = 20;

   // Depth of the command queue between front end and walk engine.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes, taken from paddr[2].
   localparam logic REG_PROTECTED = 1'b0;
   localparam logic REG_DIR_BASE  = 1'b1;

   // Input transaction opcodes.
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_MEM_RESP  = 1'b1;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_ADDR = 2'd1,
      KIND_GP   = 2'd2,
      KIND_PF   = 2'd3
   } kind_type;

   // Page walk phase kept by the walk engine.
   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_DIR  = 2'd1,
      PHASE_TBL  = 2'd2
   } walk_phase_type;

   // Front end sequencer states.
   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_QUOT,
      FRONT_SLOT,
      FRONT_LOOKUP,
      FRONT_PUSH
   } front_state_type;

   // Input transaction.
   typedef struct packed {
      logic        opcode;
      logic [31:0] lin_addr;
      logic        is_write;
      logic [1:0]  cpl;
      logic [31:0] mem_word;
   } req_item_type;

   // Result transaction.
   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] result_value;
   } rsp_item_type;

   // Classified command handed from the front end to the walk engine.
   typedef struct packed {
      logic        is_resp;
      logic        hit;
      logic [31:0] lin_addr;
      logic        is_write;
      logic [1:0]  cpl;
      logic [31:0] word;
   } cmd_type;

   // Width of a TLB slot index for a given number of entries.
   function automatic int idx_width(input int entries);
      return (entries > 1) ? $clog2(entries) : 1;
   endfunction

   // Width that holds any page number divided by the number of entries.
   function automatic int tag_width(input int entries);
      int w;
      w = VPN_W - $clog2(entries + 1) + 1;
      return (w > 0) ? w : 1;
   endfunction

endpackage

`default_nettype wire

FILE: design/two_level_page_walker_tlb.sv
// ----------------------------------------------------------------------------
// two_level_page_walker_tlb: i386 two-level page walker with a TLB
// Translates linear addresses through a page directory and page tables,
// caching table words in a direct-mapped TLB.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a rising edge with start high and busy
//   low. opcode 0 is a translate request, opcode 1 returns a memory word
//   for a read that the block asked for earlier.
//   Output: each result shows on rsp_item for one cycle with rsp_valid high;
//   the receiver cannot stall it. Kinds: memory read request, translated
//   address, protection fault, page fault. Some transactions (a request
//   during a walk, a response while idle) produce no result.
//   Flow: a memory response passes the queue and the walk engine; a translate
//   request first passes quotient, remainder, TLB read and compare. busy
//   falls in the result cycle, so the next transaction can be taken then;
//   the front end sequencer handles one transaction at a time.
//   Reset: the walk returns to idle, the registers clear and a clearing pass
//   over the TLB valid bits runs with busy high.
//   Configuration writes on the APB port are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_walker_tlb
   import ptw_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire req_item_type req_item,
   output      logic         rsp_valid,
   output      rsp_item_type rsp_item,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output      logic [31:0]  prdata,
   output      logic         pready
);

   localparam int IDX_W = idx_width(TLB_ENTRIES);
   localparam int TAG_W = tag_width(TLB_ENTRIES);
   localparam int Q_W   = $bits(cmd_type) + IDX_W + TAG_W;

   logic        protected_ff, protected_in;
   logic [19:0] dir_base_ff, dir_base_in;

   logic             accept, front_busy;
   logic             tlb_rd_en, tlb_rd_valid, tlb_clearing;
   logic [IDX_W-1:0] tlb_rd_addr;
   logic [TAG_W-1:0] tlb_rd_tag;
   logic [31:0]      tlb_rd_word;
   logic             tlb_wr_en;
   logic [IDX_W-1:0] tlb_wr_addr;
   logic [TAG_W-1:0] tlb_wr_tag;
   logic [31:0]      tlb_wr_word;

   logic             f_cmd_valid, f_cmd_ready;
   cmd_type          f_cmd;
   logic [IDX_W-1:0] f_slot;
   logic [TAG_W-1:0] f_tag;
   logic             q_valid, q_ready;
   logic [Q_W-1:0]   q_data;
   cmd_type          q_cmd;
   logic [IDX_W-1:0] q_slot;
   logic [TAG_W-1:0] q_tag;

   // Configuration registers on the APB port.
   always_comb begin
      protected_in = protected_ff;
      dir_base_in  = dir_base_ff;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_PROTECTED: protected_in = pwdata[0];
            REG_DIR_BASE:  dir_base_in  = pwdata[19:0];
            default:       protected_in = protected_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protected_ff <= 1'b0;
         dir_base_ff  <= '0;
      end else begin
         protected_ff <= protected_in;
         dir_base_ff  <= dir_base_in;
      end
   end

   assign prdata = (paddr[2] == REG_DIR_BASE) ? {12'd0, dir_base_ff} : {31'd0, protected_ff};
   assign pready = 1'b1;

   // Intake handshake.
   assign busy   = front_busy || q_valid || tlb_clearing;
   assign accept = start && !busy;

   ptw_front #(.TLB_ENTRIES(TLB_ENTRIES)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_item     (req_item),
      .front_busy   (front_busy),
      .tlb_rd_en    (tlb_rd_en),
      .tlb_rd_addr  (tlb_rd_addr),
      .tlb_rd_valid (tlb_rd_valid),
      .tlb_rd_tag   (tlb_rd_tag),
      .tlb_rd_word  (tlb_rd_word),
      .cmd_valid    (f_cmd_valid),
      .cmd_ready    (f_cmd_ready),
      .cmd          (f_cmd),
      .cmd_slot     (f_slot),
      .cmd_tag      (f_tag)
   );

   ptw_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_cmd_valid),
      .push_ready (f_cmd_ready),
      .push_data  ({f_cmd, f_slot, f_tag}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign {q_cmd, q_slot, q_tag} = q_data;

   ptw_back #(.TLB_ENTRIES(TLB_ENTRIES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_valid),
      .cmd_ready        (q_ready),
      .cmd              (q_cmd),
      .cmd_slot         (q_slot),
      .cmd_tag          (q_tag),
      .protected_enable (protected_ff),
      .dir_base_frame   (dir_base_ff),
      .tlb_wr_en        (tlb_wr_en),
      .tlb_wr_addr      (tlb_wr_addr),
      .tlb_wr_tag       (tlb_wr_tag),
      .tlb_wr_word      (tlb_wr_word),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

   ptw_tlb #(.TLB_ENTRIES(TLB_ENTRIES)) u_tlb (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (tlb_rd_en),
      .rd_addr  (tlb_rd_addr),
      .rd_valid (tlb_rd_valid),
      .rd_tag   (tlb_rd_tag),
      .rd_word  (tlb_rd_word),
      .wr_en    (tlb_wr_en),
      .wr_addr  (tlb_wr_addr),
      .wr_tag   (tlb_wr_tag),
      .wr_word  (tlb_wr_word),
      .clearing (tlb_clearing)
   );

endmodule

`default_nettype wire

FILE: design/ptw_tlb.sv
// ----------------------------------------------------------------------------
// ptw_tlb: direct-mapped translation cache store
// Holds a valid bit, a tag and the page-table word per slot. Reads are
// registered. After reset a clearing pass walks the valid bits, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_tlb
   import ptw_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rd_en,
   input  wire logic [idx_width(TLB_ENTRIES)-1:0] rd_addr,
   output      logic                             rd_valid,
   output      logic [tag_width(TLB_ENTRIES)-1:0] rd_tag,
   output      logic [31:0]                      rd_word,
   input  wire logic                             wr_en,
   input  wire logic [idx_width(TLB_ENTRIES)-1:0] wr_addr,
   input  wire logic [tag_width(TLB_ENTRIES)-1:0] wr_tag,
   input  wire logic [31:0]                      wr_word,
   output      logic                             clearing
);

   localparam int IDX_W = idx_width(TLB_ENTRIES);
   localparam int TAG_W = tag_width(TLB_ENTRIES);

   logic             valid_mem_ff [TLB_ENTRIES];
   logic [TAG_W-1:0] tag_mem_ff   [TLB_ENTRIES];
   logic [31:0]      word_mem_ff  [TLB_ENTRIES];

   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic             rd_valid_ff;
   logic [TAG_W-1:0] rd_tag_ff;
   logic [31:0]      rd_word_ff;

   // Clearing pass sequencing.
   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         if (clr_idx_ff == IDX_W'(TLB_ENTRIES - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Valid bits: cleared by the pass, set by a fill.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         valid_mem_ff[clr_idx_ff] <= 1'b0;
      end else if (wr_en) begin
         valid_mem_ff[wr_addr] <= 1'b1;
      end
   end

   // Tag and word store, written only by a fill.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_addr]  <= wr_tag;
         word_mem_ff[wr_addr] <= wr_word;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_mem_ff[rd_addr];
         rd_tag_ff   <= tag_mem_ff[rd_addr];
         rd_word_ff  <= word_mem_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_tag   = rd_tag_ff;
   assign rd_word  = rd_word_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

FILE: design/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front: transaction intake and classification
// Takes one input transaction, splits the page number into TLB slot and tag,
// looks the slot up and hands a classified command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_front
   import ptw_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire req_item_type                      req_item,
   output      logic                              front_busy,
   output      logic                              tlb_rd_en,
   output      logic [idx_width(TLB_ENTRIES)-1:0] tlb_rd_addr,
   input  wire logic                              tlb_rd_valid,
   input  wire logic [tag_width(TLB_ENTRIES)-1:0] tlb_rd_tag,
   input  wire logic [31:0]                       tlb_rd_word,
   output      logic                              cmd_valid,
   input  wire logic                              cmd_ready,
   output      cmd_type                           cmd,
   output      logic [idx_width(TLB_ENTRIES)-1:0] cmd_slot,
   output      logic [tag_width(TLB_ENTRIES)-1:0] cmd_tag
);

   localparam int IDX_W  = idx_width(TLB_ENTRIES);
   localparam int TAG_W  = tag_width(TLB_ENTRIES);
   localparam int LOG_N  = $clog2(TLB_ENTRIES);
   localparam int SHIFT  = VPN_W + LOG_N;
   localparam int PROD_W = 2 * VPN_W + 1;
   // Rounded-up reciprocal: exact quotient for every page number.
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(TLB_ENTRIES) - 64'd1) / 64'(TLB_ENTRIES);
   localparam logic [VPN_W:0] RECIP = RECIP_FULL[VPN_W:0];

   front_state_type  state_ff, state_in;
   req_item_type     item_ff, item_in;
   logic [TAG_W-1:0] quot_ff, quot_in;
   logic [IDX_W-1:0] slot_ff, slot_in;

   logic [VPN_W-1:0]  vpn;
   logic [PROD_W-1:0] quot_prod;
   logic [VPN_W:0]    back_prod;
   logic [VPN_W-1:0]  remainder;

   // Quotient and remainder of the page number by the entry count.
   assign vpn       = item_ff.lin_addr[31:12];
   assign quot_prod = PROD_W'(vpn) * PROD_W'(RECIP);
   assign back_prod = (VPN_W + 1)'(quot_ff) * (VPN_W + 1)'(TLB_ENTRIES);
   assign remainder = vpn - back_prod[VPN_W-1:0];

   // Sequencer for one transaction at a time.
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      quot_in     = quot_ff;
      slot_in     = slot_ff;
      tlb_rd_en   = 1'b0;
      cmd_valid   = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               item_in  = req_item;
               state_in = (req_item.opcode == OP_MEM_RESP) ? FRONT_PUSH : FRONT_QUOT;
            end
         end
         FRONT_QUOT: begin
            quot_in  = TAG_W'(quot_prod >> SHIFT);
            state_in = FRONT_SLOT;
         end
         FRONT_SLOT: begin
            slot_in  = remainder[IDX_W-1:0];
            state_in = FRONT_LOOKUP;
         end
         FRONT_LOOKUP: begin
            tlb_rd_en = 1'b1;
            state_in  = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            cmd_valid = 1'b1;
            if (cmd_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      quot_ff <= quot_in;
      slot_ff <= slot_in;
   end

   // Classified command: responses carry the memory word, requests the TLB word.
   always_comb begin
      cmd.is_resp  = (item_ff.opcode == OP_MEM_RESP);
      cmd.hit      = (item_ff.opcode == OP_TRANSLATE) && tlb_rd_valid &&
                     (tlb_rd_tag == quot_ff);
      cmd.lin_addr = item_ff.lin_addr;
      cmd.is_write = item_ff.is_write;
      cmd.cpl      = item_ff.cpl;
      cmd.word     = (item_ff.opcode == OP_MEM_RESP) ? item_ff.mem_word : tlb_rd_word;
   end

   assign cmd_slot    = slot_ff;
   assign cmd_tag     = quot_ff;
   assign tlb_rd_addr = slot_ff;
   assign front_busy  = (state_ff != FRONT_IDLE);

endmodule

`default_nettype wire

FILE: design/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue: short command queue
// A small FIFO that decouples the front end from the walk engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_queue
   import ptw_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             pop_valid,
   input  wire logic             pop_ready,
   output      logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != COUNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_ready && pop_valid;
   assign pop_data   = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back: page walk engine
// Executes classified commands against the walk phase, checks directory and
// table entries, fills the TLB and registers at most one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_back
   import ptw_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   output      logic                              cmd_ready,
   input  wire cmd_type                           cmd,
   input  wire logic [idx_width(TLB_ENTRIES)-1:0] cmd_slot,
   input  wire logic [tag_width(TLB_ENTRIES)-1:0] cmd_tag,
   input  wire logic                              protected_enable,
   input  wire logic [19:0]                       dir_base_frame,
   output      logic                              tlb_wr_en,
   output      logic [idx_width(TLB_ENTRIES)-1:0] tlb_wr_addr,
   output      logic [tag_width(TLB_ENTRIES)-1:0] tlb_wr_tag,
   output      logic [31:0]                       tlb_wr_word,
   output      logic                              rsp_valid,
   output      rsp_item_type                      rsp_item
);

   localparam int IDX_W = idx_width(TLB_ENTRIES);
   localparam int TAG_W = tag_width(TLB_ENTRIES);

   walk_phase_type   phase_ff, phase_in;
   logic [31:0]      held_addr_ff, held_addr_in;
   logic             held_write_ff, held_write_in;
   logic [1:0]       held_cpl_ff, held_cpl_in;
   logic [IDX_W-1:0] held_slot_ff, held_slot_in;
   logic [TAG_W-1:0] held_tag_ff, held_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   // True when an entry word denies the access.
   function automatic logic entry_denies(input logic [31:0] word, input logic wr,
                                         input logic [1:0] level);
      return !word[0] || (!word[1] && wr) || (!word[2] && (level == 2'd3));
   endfunction

   // Final result of applying a table word to a request.
   function automatic rsp_item_type finish(input logic [31:0] word,
                                           input logic [31:0] addr, input logic wr,
                                           input logic [1:0] level);
      rsp_item_type r;
      if (entry_denies(word, wr, level)) begin
         r.result_kind  = KIND_PF;
         r.result_value = addr;
      end else begin
         r.result_kind  = KIND_ADDR;
         r.result_value = {word[31:12], addr[11:0]};
      end
      return r;
   endfunction

   // Command execution; every command is taken in the cycle it shows up.
   always_comb begin
      phase_in      = phase_ff;
      held_addr_in  = held_addr_ff;
      held_write_in = held_write_ff;
      held_cpl_in   = held_cpl_ff;
      held_slot_in  = held_slot_ff;
      held_tag_in   = held_tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      tlb_wr_en     = 1'b0;
      if (cmd_valid) begin
         if (!cmd.is_resp) begin
            // Translate requests are dropped while a walk is running.
            if (phase_ff == PHASE_IDLE) begin
               rsp_valid_in = 1'b1;
               if (!protected_enable) begin
                  rsp_item_in.result_kind  = KIND_GP;
                  rsp_item_in.result_value = '0;
               end else begin
                  held_addr_in  = cmd.lin_addr;
                  held_write_in = cmd.is_write;
                  held_cpl_in   = cmd.cpl;
                  held_slot_in  = cmd_slot;
                  held_tag_in   = cmd_tag;
                  if (cmd.hit) begin
                     rsp_item_in = finish(cmd.word, cmd.lin_addr, cmd.is_write, cmd.cpl);
                  end else begin
                     phase_in                 = PHASE_DIR;
                     rsp_item_in.result_kind  = KIND_READ;
                     rsp_item_in.result_value =
                        {dir_base_frame, cmd.lin_addr[31:22], 2'b00};
                  end
               end
            end
         end else begin
            case (phase_ff)
               PHASE_DIR: begin
                  rsp_valid_in = 1'b1;
                  if (entry_denies(cmd.word, held_write_ff, held_cpl_ff)) begin
                     phase_in                 = PHASE_IDLE;
                     rsp_item_in.result_kind  = KIND_PF;
                     rsp_item_in.result_value = held_addr_ff;
                  end else begin
                     phase_in                 = PHASE_TBL;
                     rsp_item_in.result_kind  = KIND_READ;
                     rsp_item_in.result_value =
                        {cmd.word[31:12], held_addr_ff[21:12], 2'b00};
                  end
               end
               PHASE_TBL: begin
                  // The table word is cached even when it is not present.
                  rsp_valid_in = 1'b1;
                  tlb_wr_en    = 1'b1;
                  phase_in     = PHASE_IDLE;
                  rsp_item_in  = finish(cmd.word, held_addr_ff, held_write_ff,
                                        held_cpl_ff);
               end
               default: begin
                  // A stray response while idle is ignored.
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_addr_ff  <= '0;
         held_write_ff <= 1'b0;
         held_cpl_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_addr_ff  <= held_addr_in;
         held_write_ff <= held_write_in;
         held_cpl_ff   <= held_cpl_in;
      end
   end

   always_ff @(posedge clock) begin
      held_slot_ff <= held_slot_in;
      held_tag_ff  <= held_tag_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign cmd_ready   = 1'b1;
   assign tlb_wr_addr = held_slot_ff;
   assign tlb_wr_tag  = held_tag_ff;
   assign tlb_wr_word = cmd.word;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;

endmodule

`default_nettype wire

FILE: design/ptw_checker.sv
// ----------------------------------------------------------------------------
// ptw_checker: port-level checks of the page walker
// Watches the handshake and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_checker
   import ptw_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         rsp_valid,
   input wire rsp_item_type rsp_item
);

   // Reset starts the TLB clearing pass, so the block reports busy.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // An accepted transaction keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted transaction");

   // Results come one transaction at a time, never in adjacent cycles.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in two adjacent cycles");

   // A result follows a cycle in which the block was busy with its command.
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding busy cycle");

   // A protection fault carries a zero value.
   a_gp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.result_kind == KIND_GP)) |-> (rsp_item.result_value == '0))
      else $error("protection fault with nonzero value");

endmodule

bind two_level_page_walker_tlb ptw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: tb/ptw_checker.sv
// ----------------------------------------------------------------------------
// ptw_scoreboard: result checker for the two-level page walker
// Watches the request, result and configuration channels of the walker. It
// keeps its own copy of the walk state, the register values and the
// direct-mapped TLB. It works out the result of every accepted transaction
// and compares each result transaction field by field with the oldest one
// still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ptw_scoreboard
   import ptw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output int           fail_count,
   output int           pending_count
);

   localparam int SLOTS = TLB_ENTRIES_DEFAULT;

   // Register copies.
   logic        prot_mode;
   logic [19:0] dir_frame;

   // Walk in progress.
   walk_phase_type walk_phase;
   logic [31:0]    walk_addr;
   logic           walk_write;
   logic [1:0]     walk_cpl;

   // TLB copy: the tag holds the page number divided by the number of slots.
   logic        slot_valid [SLOTS];
   logic [19:0] slot_tag   [SLOTS];
   logic [31:0] slot_word  [SLOTS];

   // Results owed by the walker, oldest first.
   rsp_item_type owed_results [$];

   // An entry denies the access when it is not present, when a write meets a
   // read-only entry, or when privilege 3 meets a supervisor entry.
   function automatic logic access_denied(input logic [31:0] word, input logic wr,
                                          input logic [1:0] lvl);
      return !word[0] || (!word[1] && wr) || (!word[2] && lvl == 2'd3);
   endfunction

   // Applies a page-table word to the request under walk.
   function automatic rsp_item_type table_result(input logic [31:0] word);
      rsp_item_type r;
      if (access_denied(word, walk_write, walk_cpl)) begin
         r.result_kind  = KIND_PF;
         r.result_value = walk_addr;
      end else begin
         r.result_kind  = KIND_ADDR;
         r.result_value = {word[31:12], 12'h000} + {20'h00000, walk_addr[11:0]};
      end
      return r;
   endfunction

   // Advances the walker copy by one accepted transaction.
   task automatic step_walker(input req_item_type it);
      int           vpn;
      int           slot;
      int           tag;
      rsp_item_type r;
      if (it.opcode == OP_TRANSLATE) begin
         // A request during a walk is dropped without a result.
         if (walk_phase == PHASE_IDLE) begin
            if (!prot_mode) begin
               r.result_kind  = KIND_GP;
               r.result_value = 32'h0;
               owed_results.push_back(r);
            end else begin
               walk_addr  = it.lin_addr;
               walk_write = it.is_write;
               walk_cpl   = it.cpl;
               vpn  = int'(it.lin_addr[31:12]);
               slot = vpn % SLOTS;
               tag  = vpn / SLOTS;
               if (slot_valid[slot] && slot_tag[slot] == 20'(tag)) begin
                  owed_results.push_back(table_result(slot_word[slot]));
               end else begin
                  walk_phase     = PHASE_DIR;
                  r.result_kind  = KIND_READ;
                  r.result_value = {dir_frame, 12'h000}
                                 + {20'h00000, it.lin_addr[31:22], 2'b00};
                  owed_results.push_back(r);
               end
            end
         end
      end else if (walk_phase == PHASE_DIR) begin
         // A failing directory entry ends the walk and caches nothing.
         if (access_denied(it.mem_word, walk_write, walk_cpl)) begin
            walk_phase     = PHASE_IDLE;
            r.result_kind  = KIND_PF;
            r.result_value = walk_addr;
         end else begin
            walk_phase     = PHASE_TBL;
            r.result_kind  = KIND_READ;
            r.result_value = {it.mem_word[31:12], 12'h000}
                           + {20'h00000, walk_addr[21:12], 2'b00};
         end
         owed_results.push_back(r);
      end else if (walk_phase == PHASE_TBL) begin
         // The table word is cached whether or not it is present.
         vpn  = int'(walk_addr[31:12]);
         slot = vpn % SLOTS;
         slot_valid[slot] = 1'b1;
         slot_tag[slot]   = 20'(vpn / SLOTS);
         slot_word[slot]  = it.mem_word;
         walk_phase       = PHASE_IDLE;
         owed_results.push_back(table_result(it.mem_word));
      end
      // A memory response while idle is dropped without a result.
   endtask

   // Results are compared before new transactions are predicted, since a new
   // transaction can be taken at the edge that ends a result cycle.
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         prot_mode  = 1'b0;
         dir_frame  = 20'h0;
         walk_phase = PHASE_IDLE;
         walk_addr  = 32'h0;
         walk_write = 1'b0;
         walk_cpl   = 2'd0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
         end
         owed_results.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual kind %0d value %h",
                        $time, rsp_item.result_kind, rsp_item.result_value);
            end else begin
               want = owed_results.pop_front();
               if (rsp_item.result_kind !== want.result_kind) begin
                  fail_count++;
                  $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                           $time, want.result_kind, rsp_item.result_kind);
               end
               if (rsp_item.result_value !== want.result_value) begin
                  fail_count++;
                  $display("%0t: result_value mismatch, expected %h, actual %h",
                           $time, want.result_value, rsp_item.result_value);
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_PROTECTED) begin
               prot_mode = pwdata[0];
            end else begin
               dir_frame = pwdata[19:0];
            end
         end
         if (start && !busy) begin
            step_walker(req_item);
         end
      end
      pending_count = owed_results.size();
   end

endmodule

FILE: tb/tb_two_level_page_walker_tlb.sv
// ----------------------------------------------------------------------------
// tb_two_level_page_walker_tlb: testbench of the two-level page walker
// Drives translate requests and memory responses into the walker, writes
// its registers between phases and leaves the checking to ptw_scoreboard. A
// directed part covers faults, hits, evictions and walks that are
// interrupted; random phases then run well-formed walks over a small page
// pool with some broken sequences and noise, under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_two_level_page_walker_tlb;
   import ptw_pkg::*;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         psel     = 1'b0;
   logic         penable  = 1'b0;
   logic         pwrite   = 1'b0;
   logic [2:0]   paddr    = 3'd0;
   logic [31:0]  pwdata   = 32'h0;

   logic         busy;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic [31:0]  prdata;
   logic         pready;

   int           fail_count;
   int           pending_count;
   int           items_sent = 0;
   bit           idle_enable = 1'b1;
   logic [19:0]  page_pool [8];

   two_level_page_walker_tlb u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   ptw_scoreboard u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // Offers one transaction and holds it until the walker takes it.
   task automatic drive_item(input req_item_type item);
      while (idle_enable && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      items_sent++;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Waits until every owed result has come and the walker has settled.
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic csr_write(input logic idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_translate(input logic [31:0] addr, input logic wr,
                                 input logic [1:0] lvl);
      req_item_type it;
      it.opcode   = OP_TRANSLATE;
      it.lin_addr = addr;
      it.is_write = wr;
      it.cpl      = lvl;
      it.mem_word = $urandom;
      drive_item(it);
   endtask

   task automatic send_memory(input logic [31:0] word);
      req_item_type it;
      it.opcode   = OP_MEM_RESP;
      it.lin_addr = $urandom;
      it.is_write = 1'($urandom);
      it.cpl      = 2'($urandom);
      it.mem_word = word;
      drive_item(it);
   endtask

   // Entry words are mostly permissive so that walks usually reach the table.
   function automatic logic [31:0] entry_word();
      logic [31:0] w;
      w    = $urandom;
      w[0] = ($urandom_range(0, 99) < 92);
      w[1] = ($urandom_range(0, 99) < 85);
      w[2] = ($urandom_range(0, 99) < 85);
      return w;
   endfunction

   // Addresses mostly come from the page pool, so the TLB hits and evicts.
   function automatic logic [31:0] pool_addr();
      logic [31:0] a;
      a = $urandom;
      if ($urandom_range(0, 99) < 75) begin
         a[31:12] = page_pool[$urandom_range(0, 7)];
      end
      return a;
   endfunction

   // Half of the pool shares one TLB slot, with random tags.
   task automatic fill_pool();
      logic [5:0] shared_slot;
      shared_slot = 6'($urandom);
      for (int i = 0; i < 8; i++) begin
         if (i < 4) begin
            page_pool[i] = {14'($urandom), shared_slot};
         end else begin
            page_pool[i] = 20'($urandom);
         end
      end
   endtask

   // One random phase: mostly complete walks, some broken ones, some noise.
   task automatic run_phase(input int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            send_translate(pool_addr(), 1'($urandom), 2'($urandom));
            send_memory(entry_word());
            send_memory(entry_word());
         end else if (pick < 90) begin
            send_translate(pool_addr(), 1'($urandom), 2'($urandom));
            if ($urandom_range(0, 1) == 0) begin
               send_translate(pool_addr(), 1'($urandom), 2'($urandom));
            end
            send_memory(entry_word());
         end else if (pick < 95) begin
            send_memory($urandom);
         end else begin
            send_translate($urandom, 1'($urandom), 2'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      logic        phase_prot [5];
      logic [31:0] phase_base [5];
      bit          phase_idle [5];
      int          phase_len  [5];

      phase_prot = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      phase_base = '{$urandom, 32'h0, 32'h000F_FFFF, $urandom, $urandom};
      phase_idle = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      phase_len  = '{350, 350, 350, 120, 380};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Protected mode off after reset, then a response while idle.
      send_translate(32'h1234_5678, 1'b0, 2'd0);
      send_memory(32'hFFFF_FFFF);
      wait_idle();
      csr_write(REG_PROTECTED, 32'h0000_0001);
      csr_write(REG_DIR_BASE, 32'hFFFF_FFFF);

      // Full walk at the top of the address space, then a hit on it.
      send_translate(32'hFFFF_FFFF, 1'b1, 2'd3);
      send_memory(32'hFFFF_FFFF);
      send_memory(32'hFFFF_F007);
      send_translate(32'hFFFF_FFFF, 1'b1, 2'd3);

      // Directory entry not present, then a stray response.
      send_translate(32'h0000_0000, 1'b0, 2'd0);
      send_memory(32'h0000_0000);
      send_memory(32'h0000_0007);

      // Directory entry read-only under a supervisor write, then supervisor-only
      // under privilege 3.
      send_translate(32'h0040_1000, 1'b1, 2'd0);
      send_memory(32'h0000_5005);
      send_translate(32'h0040_1000, 1'b0, 2'd3);
      send_memory(32'h0000_5003);

      // Table entry not present is still cached and faults again on a hit.
      send_translate(32'h0080_2ABC, 1'b0, 2'd2);
      send_memory(32'h0000_6007);
      send_memory(32'h0000_7006);
      send_translate(32'h0080_2ABC, 1'b0, 2'd0);

      // A request during a walk is dropped; the walk goes on.
      send_translate(32'h0100_4000, 1'b0, 2'd1);
      send_translate(32'h0200_5000, 1'b0, 2'd0);
      send_memory(32'h0000_0007);
      send_memory(32'h0009_A007);

      // A page in the same TLB slot evicts the previous one.
      send_translate(32'h0104_4321, 1'b1, 2'd3);
      send_memory(32'h0000_0007);
      send_memory(32'h000B_C005);
      send_translate(32'h0100_4000, 1'b0, 2'd0);
      send_memory(32'h0000_0007);
      send_memory(32'h0000_0007);

      // Protected mode turned off in the middle of a walk.
      send_translate(32'h0300_6000, 1'b0, 2'd0);
      wait_idle();
      csr_write(REG_PROTECTED, 32'h0000_0000);
      send_memory(32'h0000_0007);
      send_memory(32'h000C_D007);
      send_translate(32'h0300_6000, 1'b0, 2'd0);

      // Random phases under several register settings.
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         csr_write(REG_PROTECTED, {31'h0, phase_prot[p]});
         csr_write(REG_DIR_BASE, phase_base[p]);
         fill_pool();
         idle_enable = phase_idle[p];
         run_phase(phase_len[p]);
      end

      // Drain the owed results, then let the pipeline run dry.
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: two_level_page_walker_tlb.f
design/ptw_pkg.sv
design/ptw_tlb.sv
design/ptw_front.sv
design/ptw_queue.sv
design/ptw_back.sv
design/two_level_page_walker_tlb.sv
design/ptw_checker.sv
tb/ptw_checker.sv
tb/tb_two_level_page_walker_tlb.sv
